@@ sv/dihedral_transition_counter_unit_assert.svh @@
// Assertion macros used by the dihedral transition counter RTL.
`ifndef DIHEDRAL_TRANSITION_COUNTER_UNIT_ASSERT_SVH
`define DIHEDRAL_TRANSITION_COUNTER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define DTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtc assertion failed");

// Check a consequence in the cycle after its trigger.
`define DTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtc assertion failed");

`endif

@@ sv/dtc_pkg.sv @@
// Package with constants, types and table functions of the dihedral transition counter.
package dtc_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int TURN            = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN       = TURN / 2;
    localparam int QUARTER_NUM     = 90 << ANGLE_FRAC_BITS;

    localparam int ANGLE_W = 18;
    localparam int TO_W    = 16;
    localparam int COUNT_W = 32;
    localparam int UNW_W   = 33;

    // Divider operand widths: dividend is (a - angle + 2 turns), always positive.
    localparam int DVD_W = $clog2(3 * TURN + (1 << (ANGLE_W - 1)) + 1);
    localparam int DVS_W = $clog2(TURN + 1);
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int WORK_W = DVD_W + 1;

    localparam int PROD_W = TO_W + DVS_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    typedef enum logic [1:0] {
        REG_MULTIPLICITY = 2'd0,
        REG_PHASE_SIGN   = 2'd1,
        REG_STRICT_MODE  = 2'd2
    } cfg_reg_t;

    localparam logic [1:0] PHASE_POS  = 2'b01;
    localparam logic [1:0] PHASE_ZERO = 2'b00;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    // Clamp multiplicity codes into 1..6.
    function automatic logic [2:0] eff_mult(logic [2:0] m);
        logic [2:0] r;
        begin
            unique case (m)
                3'd0:    r = 3'd1;
                3'd7:    r = 3'd6;
                default: r = m;
            endcase
            return r;
        end
    endfunction

    // Well spacing, one turn over the multiplicity.
    function automatic logic [DVS_W-1:0] spacing(logic [2:0] me);
        logic [DVS_W-1:0] r;
        begin
            unique case (me)
                3'd1:    r = DVS_W'(TURN / 1);
                3'd2:    r = DVS_W'(TURN / 2);
                3'd3:    r = DVS_W'(TURN / 3);
                3'd4:    r = DVS_W'(TURN / 4);
                3'd5:    r = DVS_W'(TURN / 5);
                default: r = DVS_W'(TURN / 6);
            endcase
            return r;
        end
    endfunction

    // Position of the reference minimum, 90*(3 - phase)/multiplicity degrees.
    function automatic logic [DVS_W-1:0] first_min(logic [2:0] me, logic [1:0] ps);
        logic             pos;
        logic             zero;
        logic [DVS_W-1:0] r;
        begin
            pos  = (ps == PHASE_POS);
            zero = (ps == PHASE_ZERO);
            unique case (me)
                3'd1: r = pos ? DVS_W'(2 * QUARTER_NUM / 1) :
                          zero ? DVS_W'(3 * QUARTER_NUM / 1) : DVS_W'(4 * QUARTER_NUM / 1);
                3'd2: r = pos ? DVS_W'(2 * QUARTER_NUM / 2) :
                          zero ? DVS_W'(3 * QUARTER_NUM / 2) : DVS_W'(4 * QUARTER_NUM / 2);
                3'd3: r = pos ? DVS_W'(2 * QUARTER_NUM / 3) :
                          zero ? DVS_W'(3 * QUARTER_NUM / 3) : DVS_W'(4 * QUARTER_NUM / 3);
                3'd4: r = pos ? DVS_W'(2 * QUARTER_NUM / 4) :
                          zero ? DVS_W'(3 * QUARTER_NUM / 4) : DVS_W'(4 * QUARTER_NUM / 4);
                3'd5: r = pos ? DVS_W'(2 * QUARTER_NUM / 5) :
                          zero ? DVS_W'(3 * QUARTER_NUM / 5) : DVS_W'(4 * QUARTER_NUM / 5);
                default: r = pos ? DVS_W'(2 * QUARTER_NUM / 6) :
                          zero ? DVS_W'(3 * QUARTER_NUM / 6) : DVS_W'(4 * QUARTER_NUM / 6);
            endcase
            return r;
        end
    endfunction

    // Saturate a work value into the signed angle range.
    function automatic logic signed [ANGLE_W-1:0] sat_angle(logic signed [WORK_W-1:0] v);
        logic [WORK_W-ANGLE_W:0]    top;
        logic signed [ANGLE_W-1:0]  r;
        begin
            top = v[WORK_W-1:ANGLE_W-1];
            if ((&top) || !(|top))
                r = v[ANGLE_W-1:0];
            else if (v[WORK_W-1])
                r = {1'b1, {(ANGLE_W-1){1'b0}}};
            else
                r = {1'b0, {(ANGLE_W-1){1'b1}}};
            return r;
        end
    endfunction

endpackage

@@ sv/dtc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module dtc_div
    import dtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   partial;
    logic             fits;

    // Shift in the next dividend bit and try one subtract.
    assign partial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = (partial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(partial - {1'b0, dvs_reg}) : partial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ sv/dihedral_transition_counter_unit.sv @@
// Top level of the dihedral transition counter: sequencer, state and result register.
// A new input transfer is accepted only in the idle state, after the previous sample has
// passed the restoring divider (one bit per cycle) and been written to the result register.
// The result register lets the next input transfer start while a result waits.
// Reset (rst_n, async, active low) clears all history and loads register defaults.
`include "dihedral_transition_counter_unit_assert.svh"

module dihedral_transition_counter_unit
    import dtc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [2:0]                cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [ANGLE_W-1:0] angle,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      transition,
    output logic signed [ANGLE_W-1:0] current_minimum,
    output logic [COUNT_W-1:0]        transition_count,
    output logic signed [UNW_W-1:0]   unwrapped_angle
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_WRAP,
        S_UPDATE,
        S_MUL,
        S_OUT
    } state_t;

    localparam logic signed [TO_W-1:0] TO_MAX = {1'b0, {(TO_W-1){1'b1}}};
    localparam logic signed [TO_W-1:0] TO_MIN = {1'b1, {(TO_W-1){1'b0}}};
    localparam logic signed [WORK_W-1:0] TURN_W  = WORK_W'(TURN);
    localparam logic signed [WORK_W-1:0] HALF_W  = WORK_W'(HALF_TURN);
    localparam logic signed [DVS_W:0]    TURN_S  = (DVS_W + 1)'(TURN);

    state_t state_reg;

    // Configuration registers.
    logic [2:0] mult_reg;
    logic [1:0] phase_reg;
    logic       strict_reg;

    // Model history.
    logic                      primed_reg;
    logic signed [ANGLE_W-1:0] prev_min_reg;
    logic signed [ANGLE_W-1:0] prev_angle_reg;
    logic signed [TO_W-1:0]    turn_offset_reg;
    logic [COUNT_W-1:0]        count_reg;

    // Result register.
    logic                      out_valid_reg;
    logic                      trans_out_reg;
    logic signed [ANGLE_W-1:0] min_out_reg;
    logic [COUNT_W-1:0]        count_out_reg;
    logic signed [UNW_W-1:0]   unw_out_reg;

    // Working registers for the item in flight.
    logic signed [ANGLE_W-1:0] angle_reg;
    logic [DVS_W-1:0]          d_reg;
    logic signed [WORK_W-1:0]  nm_raw_reg;
    logic signed [ANGLE_W-1:0] nm_reg;
    logic [ANGLE_W:0]          diff_reg;
    logic                      up_reg;
    logic                      dn_reg;
    logic                      trans_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2:0]               me;
    logic [DVS_W-1:0]         d_now;
    logic [DVS_W-1:0]         a_now;
    logic signed [WORK_W-1:0] phi_w;
    logic signed [WORK_W-1:0] dividend_w;
    logic [DVS_W:0]           two_r;
    logic                     round_up;
    logic signed [WORK_W-1:0] nm_raw_next;
    logic signed [WORK_W-1:0] nm_wrapped;
    logic signed [WORK_W-1:0] prev_w;
    logic signed [WORK_W-1:0] delta_w;
    logic [ANGLE_W:0]         diff_next;
    logic                     strict_hit;
    logic                     trans_now;
    logic signed [SUM_W-1:0]  unw_sum;
    logic signed [UNW_W-1:0]  unw_sat;
    logic                     out_free;

    // ---------------------------------------------------------------
    // Snap path: dividend = a - angle + 2 turns, kept positive so the
    // floor quotient only differs from the true one by an even count.
    // ---------------------------------------------------------------
    assign me         = eff_mult(mult_reg);
    assign d_now      = spacing(me);
    assign a_now      = first_min(me, phase_reg);
    assign phi_w      = WORK_W'(angle_reg);
    assign dividend_w = $signed(WORK_W'(a_now)) - phi_w + (TURN_W <<< 1);

    assign div_req.start    = (state_reg == S_LOAD);
    assign div_req.dividend = dividend_w[DVD_W-1:0];
    assign div_req.divisor  = d_now;

    dtc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Round half to even: step one well further when the remainder passes
    // half a spacing, or sits exactly on it with an odd quotient.
    assign two_r    = {div_rsp.remainder, 1'b0};
    assign round_up = (two_r > {1'b0, d_reg}) ||
                      ((two_r == {1'b0, d_reg}) && div_rsp.quotient[0]);

    // a - k*d reduces to angle + remainder, less one spacing when rounding up.
    assign nm_raw_next = phi_w + $signed(WORK_W'(div_rsp.remainder))
                         - (round_up ? $signed(WORK_W'(d_reg)) : '0);

    assign nm_wrapped = (nm_raw_reg >= TURN_W) ? (nm_raw_reg - TURN_W) : nm_raw_reg;

    // Strict distance and seam crossing checks.
    assign prev_w    = WORK_W'(prev_min_reg);
    assign delta_w   = prev_w - phi_w;
    assign diff_next = delta_w[WORK_W-1] ? (ANGLE_W + 1)'(-delta_w) : delta_w[ANGLE_W:0];

    assign strict_hit = (WORK_W'(diff_reg) > WORK_W'(d_reg)) &&
                        ((WORK_W'(diff_reg) + WORK_W'(d_reg)) < TURN_W);

    always_comb
    begin
        if (strict_reg)
            trans_now = strict_hit;
        else
            trans_now = (nm_reg != prev_min_reg);
    end

    // Unwrapped angle, clipped to the result width.
    assign unw_sum = SUM_W'(angle_reg) + SUM_W'(prod_reg);

    always_comb
    begin
        if ((&unw_sum[SUM_W-1:UNW_W-1]) || !(|unw_sum[SUM_W-1:UNW_W-1]))
            unw_sat = unw_sum[UNW_W-1:0];
        else if (unw_sum[SUM_W-1])
            unw_sat = {1'b1, {(UNW_W-1){1'b0}}};
        else
            unw_sat = {1'b0, {(UNW_W-1){1'b1}}};
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Sequencer, history and result register.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mult_reg        <= 3'd3;
            phase_reg       <= PHASE_POS;
            strict_reg      <= 1'b0;
            primed_reg      <= 1'b0;
            prev_min_reg    <= '0;
            prev_angle_reg  <= '0;
            turn_offset_reg <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            trans_out_reg   <= 1'b0;
            min_out_reg     <= '0;
            count_out_reg   <= '0;
            unw_out_reg     <= '0;
        end
        else
        begin
            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MULTIPLICITY: mult_reg   <= cfg_data;
                    REG_PHASE_SIGN:   phase_reg  <= cfg_data[1:0];
                    REG_STRICT_MODE:  strict_reg <= cfg_data[0];
                    default:          ;
                endcase
            end

            // Raise valid for a finished result, or drop it once the output
            // transfer completes.
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                        state_reg <= S_WRAP;
                end
                S_WRAP:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    // Commit the history for this sample.
                    if (!primed_reg)
                    begin
                        primed_reg   <= 1'b1;
                        prev_min_reg <= nm_reg;
                    end
                    else
                    begin
                        if (trans_now)
                        begin
                            prev_min_reg <= nm_reg;
                            if (count_reg != '1)
                                count_reg <= count_reg + 1'b1;
                        end
                        if (up_reg && turn_offset_reg != TO_MAX)
                            turn_offset_reg <= turn_offset_reg + 1'b1;
                        else if (dn_reg && turn_offset_reg != TO_MIN)
                            turn_offset_reg <= turn_offset_reg - 1'b1;
                    end
                    prev_angle_reg <= angle_reg;
                    state_reg      <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Hold until the result register is free.
                    if (out_free)
                    begin
                        trans_out_reg <= trans_reg;
                        min_out_reg   <= prev_min_reg;
                        count_out_reg <= count_reg;
                        unw_out_reg   <= unw_sat;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            angle_reg <= angle;
        if (state_reg == S_LOAD)
            d_reg <= d_now;
        if (state_reg == S_DIV && div_rsp.done)
            nm_raw_reg <= nm_raw_next;
        if (state_reg == S_WRAP)
        begin
            nm_reg   <= sat_angle(nm_wrapped);
            diff_reg <= diff_next;
            up_reg   <= phi_w < (WORK_W'(prev_angle_reg) - HALF_W);
            dn_reg   <= phi_w > (WORK_W'(prev_angle_reg) + HALF_W);
        end
        if (state_reg == S_UPDATE)
            trans_reg <= primed_reg && trans_now;
        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(turn_offset_reg) * PROD_W'(TURN_S);
    end

    assign out_valid        = out_valid_reg;
    assign transition       = trans_out_reg;
    assign current_minimum  = min_out_reg;
    assign transition_count = count_out_reg;
    assign unwrapped_angle  = unw_out_reg;

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    `DTC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `DTC_ASSERT_NEXT(a_count_never_drops, 1'b1, count_reg >= $past(count_reg))
    `DTC_ASSERT_NOW(a_trans_counted, out_valid && transition, transition_count != '0)
    `DTC_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_reg == S_DIV)

endmodule

@@ test/transition_checker.sv @@
// Checker for the dihedral transition counter: tracks settings, forecasts results, compares.
module transition_checker
    import dtc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [2:0]                cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      transition,
    input  logic signed [ANGLE_W-1:0] current_minimum,
    input  logic [COUNT_W-1:0]        transition_count,
    input  logic signed [UNW_W-1:0]   unwrapped_angle,
    output int                        mismatches,
    output int                        pending
);

    localparam longint ANGLE_LO  = -(longint'(1) << (ANGLE_W - 1));
    localparam longint ANGLE_HI  = (longint'(1) << (ANGLE_W - 1)) - 1;
    localparam longint UNW_LO    = -(longint'(1) << (UNW_W - 1));
    localparam longint UNW_HI    = (longint'(1) << (UNW_W - 1)) - 1;
    localparam longint COUNT_MAX = (longint'(1) << COUNT_W) - 1;
    localparam longint TURNS_LO  = -(longint'(1) << (TO_W - 1));
    localparam longint TURNS_HI  = (longint'(1) << (TO_W - 1)) - 1;

    typedef struct {
        logic                      transition;
        logic signed [ANGLE_W-1:0] minimum;
        logic [COUNT_W-1:0]        count;
        logic signed [UNW_W-1:0]   unwrapped;
    } sample_result_t;

    logic [2:0]     mult_cfg;
    logic [1:0]     phase_cfg;
    logic           strict_cfg;
    logic           primed;
    longint         held_minimum;
    longint         last_angle;
    longint         turns;
    longint         tally;
    sample_result_t awaited_results[$];
    sample_result_t head;

    // Out-of-range multiplicity codes fold onto 1 and 6.
    function automatic longint well_spacing();
        longint wells;
        wells = (mult_cfg == 3'd0) ? 1 : (mult_cfg == 3'd7) ? 6 : longint'(mult_cfg);
        return TURN / wells;
    endfunction

    // Snap to the closest well, ties going to the even well index.
    function automatic longint nearest_well(longint phi);
        longint spacing, wells, lean, ref_min, num, q, r, w;
        spacing = well_spacing();
        wells   = TURN / spacing;
        lean    = (phase_cfg == PHASE_POS) ? 1 : (phase_cfg == PHASE_ZERO) ? 0 : -1;
        ref_min = (QUARTER_NUM * (3 - lean)) / wells;
        num     = ref_min - phi;
        q       = num / spacing;
        if (num % spacing != 0 && num < 0)
            q--;
        r = num - q * spacing;
        if (2 * r > spacing || (2 * r == spacing && q % 2 != 0))
            q++;
        w = ref_min - q * spacing;
        if (w >= TURN)
            w -= TURN;
        if (w < ANGLE_LO)
            w = ANGLE_LO;
        else if (w > ANGLE_HI)
            w = ANGLE_HI;
        return w;
    endfunction

    // Advance the tracked history by one sample and return what the block should emit.
    function automatic sample_result_t forecast_sample(logic signed [ANGLE_W-1:0] sample);
        longint         phi, well, separation, spacing, unw;
        logic           hit;
        sample_result_t res;
        phi  = sample;
        well = nearest_well(phi);
        hit  = 1'b0;
        if (!primed)
        begin
            // first sample only seeds the history
            primed       = 1'b1;
            held_minimum = well;
            last_angle   = phi;
        end
        else
        begin
            if (strict_cfg)
            begin
                spacing    = well_spacing();
                separation = held_minimum - phi;
                if (separation < 0)
                    separation = -separation;
                if (separation > spacing && (TURN - separation) > spacing)
                begin
                    hit          = 1'b1;
                    held_minimum = well;
                end
            end
            else if (well != held_minimum)
            begin
                hit          = 1'b1;
                held_minimum = well;
            end
            if (hit && tally != COUNT_MAX)
                tally++;
            if (phi < last_angle - HALF_TURN && turns < TURNS_HI)
                turns++;
            if (phi > last_angle + HALF_TURN && turns > TURNS_LO)
                turns--;
            last_angle = phi;
        end
        unw = phi + turns * TURN;
        if (unw < UNW_LO)
            unw = UNW_LO;
        else if (unw > UNW_HI)
            unw = UNW_HI;
        res.transition = hit;
        res.minimum    = held_minimum[ANGLE_W-1:0];
        res.count      = tally[COUNT_W-1:0];
        res.unwrapped  = unw[UNW_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_cfg     = 3'd3;
            phase_cfg    = PHASE_POS;
            strict_cfg   = 1'b0;
            primed       = 1'b0;
            held_minimum = 0;
            last_angle   = 0;
            turns        = 0;
            tally        = 0;
            awaited_results.delete();
            mismatches   = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MULTIPLICITY: mult_cfg   = cfg_data;
                    REG_PHASE_SIGN:   phase_cfg  = cfg_data[1:0];
                    REG_STRICT_MODE:  strict_cfg = cfg_data[0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                awaited_results.insert(awaited_results.size(), forecast_sample(angle));
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual min %0d count %0d",
                             $time, current_minimum, transition_count);
                    mismatches++;
                end
                else
                begin
                    head = awaited_results.pop_front();
                    if (transition !== head.transition)
                    begin
                        $display("%0t: transition: expected %0d, actual %0d",
                                 $time, head.transition, transition);
                        mismatches++;
                    end
                    if (current_minimum !== head.minimum)
                    begin
                        $display("%0t: current_minimum: expected %0d, actual %0d",
                                 $time, head.minimum, current_minimum);
                        mismatches++;
                    end
                    if (transition_count !== head.count)
                    begin
                        $display("%0t: transition_count: expected %0d, actual %0d",
                                 $time, head.count, transition_count);
                        mismatches++;
                    end
                    if (unwrapped_angle !== head.unwrapped)
                    begin
                        $display("%0t: unwrapped_angle: expected %0d, actual %0d",
                                 $time, head.unwrapped, unwrapped_angle);
                        mismatches++;
                    end
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

@@ test/dihedral_transition_counter_unit_tb.sv @@
// Testbench top for the dihedral transition counter: clock, reset, stimulus and verdict.
module dihedral_transition_counter_unit_tb;
    import dtc_pkg::*;

    localparam int         CLK_HALF      = 10;
    localparam int         SETTLE        = 30;     // wait after draining, before new settings are written
    localparam int         RANDOM_PHASES = 12;
    localparam int         PHASE_ITEMS   = 138;
    localparam int         ANGLE_TOP     = (1 << (ANGLE_W - 1)) - 1;
    localparam int         ANGLE_BOTTOM  = -(1 << (ANGLE_W - 1));
    localparam logic [1:0] REG_SPARE       = 2'd3;   // unmapped index, must be ignored
    localparam logic [1:0] PHASE_NEG       = 2'b11;
    localparam logic [1:0] PHASE_NEG_ALIAS = 2'b10;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [1:0]                cfg_index;
    logic [2:0]                cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [ANGLE_W-1:0] angle;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      transition;
    logic signed [ANGLE_W-1:0] current_minimum;
    logic [COUNT_W-1:0]        transition_count;
    logic signed [UNW_W-1:0]   unwrapped_angle;
    int                        mismatches;
    int                        pending;

    // Idling knobs, in percent of cycles.
    int                        send_idle = 0;
    int                        stall_pct = 0;

    // Settings as last written, used to aim samples at wells and midpoints.
    logic [2:0]                mult_code  = 3'd3;
    logic [1:0]                phase_code = PHASE_POS;

    dihedral_transition_counter_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .angle            (angle),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .transition       (transition),
        .current_minimum  (current_minimum),
        .transition_count (transition_count),
        .unwrapped_angle  (unwrapped_angle)
    );

    transition_checker watch (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .angle            (angle),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .transition       (transition),
        .current_minimum  (current_minimum),
        .transition_count (transition_count),
        .unwrapped_angle  (unwrapped_angle),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hold off results at random; a zero knob keeps ready high.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Present one sample after a random gap, then hold it until the transfer.
    // Valid stays high on return so back-to-back samples never drop it.
    task automatic send_angle(input int value);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle    <= ANGLE_W'(value);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold one register write until its transfer; the caller drops valid.
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Drain the block, let it settle, then load a new setting.
    // Upper data bits beyond each register's width get random values.
    task automatic apply_settings(input logic [2:0] m, input logic [1:0] p, input logic s);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_MULTIPLICITY, m);
        write_reg(REG_PHASE_SIGN, {1'($urandom_range(1)), p});
        write_reg(REG_STRICT_MODE, {2'($urandom_range(3)), s});
        write_reg(REG_SPARE, 3'($urandom_range(7)));
        cfg_valid  <= 1'b0;
        mult_code  = m;
        phase_code = p;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle = 0;  stall_pct = 0;  end
            1:       begin send_idle = 87; stall_pct = 0;  end
            2:       begin send_idle = 0;  stall_pct = 87; end
            default: begin send_idle = 10; stall_pct = 10; end
        endcase
    endtask

    initial
    begin
        int                        ph;
        int                        n;
        int                        pick;
        int                        wells;
        int                        gap;
        int                        lean;
        int                        anchor;
        int                        trail;
        logic signed [ANGLE_W-1:0] raw;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MULTIPLICITY;
        cfg_data  = 3'd0;
        in_valid  = 1'b0;
        angle     = '0;
        trail     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: priming sample, half-way ties, wrap above one turn,
        // range extremes and jumps across the seam in both directions.
        send_angle(0);
        send_angle(30720);
        send_angle(-30720);
        send_angle(15360);
        send_angle(61440);
        send_angle(120000);
        send_angle(ANGLE_TOP);
        send_angle(ANGLE_BOTTOM);
        send_angle(TURN);
        send_angle(-TURN);
        send_angle(HALF_TURN);

        // One well per turn: the snapped minimum runs past the low end and clamps.
        apply_settings(3'd1, PHASE_POS, 1'b0);
        send_angle(ANGLE_BOTTOM);
        send_angle(ANGLE_TOP);
        send_angle(-100000);

        // Strict criterion with the alias pattern of a negative phase;
        // distances land exactly on the spacing and one past it.
        apply_settings(3'd2, PHASE_NEG_ALIAS, 1'b1);
        send_angle(0);
        send_angle(46080);
        send_angle(92160);
        send_angle(46079);
        send_angle(0);
        send_angle(-46081);

        // Random phases: sweep every register code and every idling mode.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_settings(3'((ph * 3) % 8), 2'(ph % 4), 1'((ph / 2) % 2));
            set_idling((ph + ph / 4) % 4);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick   = $urandom_range(99);
                wells  = (mult_code == 3'd0) ? 1 : (mult_code == 3'd7) ? 6 : int'(mult_code);
                gap    = TURN / wells;
                lean   = (phase_code == PHASE_POS) ? 1 : (phase_code == PHASE_ZERO) ? 0 : -1;
                anchor = QUARTER_NUM * (3 - lean) / wells - gap * (int'($urandom_range(5)) - 2);
                if (pick < 45)
                    trail = trail + int'($urandom_range(32768)) - 16384;      // slow drift
                else if (pick < 65)
                    trail = anchor - gap / 2 + int'($urandom_range(2)) - 1;  // midpoint tie
                else if (pick < 80)
                    trail = anchor + int'($urandom_range(2)) - 1;            // on a well
                else if (pick < 90)
                    trail = trail + ((pick < 85) ? HALF_TURN : -HALF_TURN)
                            + int'($urandom_range(1024)) - 512;               // seam jump
                else
                begin
                    raw   = ANGLE_W'($urandom);                               // anything
                    trail = raw;
                end
                // Fold back into the representable range, one turn at a time.
                while (trail > ANGLE_TOP)
                    trail -= TURN;
                while (trail < ANGLE_BOTTOM)
                    trail += TURN;
                send_angle(trail);
            end
        end

        // Drain, then allow a full latency for any stray result.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE + 10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(CLK_HALF * 2 * 800000);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ dihedral_transition_counter_unit.f @@
+incdir+sv
sv/dtc_pkg.sv
sv/dtc_div.sv
sv/dihedral_transition_counter_unit.sv
test/transition_checker.sv
test/dihedral_transition_counter_unit_tb.sv
